FILE: design/c2d_pkg.sv
// c2d_pkg: shared types and constants for the zero-padded 5x5 convolution block
// no dependencies; imported by every module of the block but c2d_ram

package c2d_pkg;

  localparam int K          = 5;
  localparam int PAD        = (K - 1) / 2;
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 8;
  localparam int COEF_ROW_W = K * COEF_W;
  localparam int DIM_W      = 7;
  localparam int DIM_RESET  = 64;
  localparam int PROD_W     = 17;
  localparam int ROW_W      = 20;
  localparam int SUM_W      = 21;
  localparam int POS_W      = 6;
  localparam int LINE_W     = (K - 1) * PIX_W;
  localparam int CFG_IDX_W  = 3;

  localparam logic [COEF_ROW_W-1:0] KERNEL_ROW_RESET = 40'h01_0101_0101;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW_4 = 3'd6;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel;
  } c2d_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] filtered_sum;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic                    last_in_frame;
  } c2d_out_t;

  typedef struct packed {
    logic         shift;
    logic         row_ok;
    logic [K-1:0] col_ok;
  } c2d_cell_ctrl_t;

endpackage

FILE: design/conv2d_zero_padded_window_top.sv
// Pipeline: a result passes the taps, the product and row-sum registers and the result
// buffer; the first result of a frame needs 2*width+3 transfers, drain ticks included.
// Throughput: one item per cycle while the result buffer has room, set by the line ram
// read one column ahead; an eight-entry buffer keeps the input open while results wait.
// Reset (synchronous): 64x64 frame, all-ones kernel, counters cleared; the line ram is
// not cleared, as only taps inside the current frame reach the products.

module conv2d_zero_padded_window_top import c2d_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  c2d_in_t               pix_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output c2d_out_t              res_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_ROW_W-1:0] cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int IRW  = $clog2(MAX_HEIGHT + 2 * PAD + 1);
  localparam int FW   = $clog2(PAD * MAX_WIDTH + PAD + 1);
  localparam int CMPW = WW + 2;
  localparam int HCMP = HW + 2;
  localparam int KIW  = $clog2(K);
  localparam int W_RESET = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
  localparam int H_RESET = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;
  localparam int FIFO_DEPTH = 8;
  localparam int FPW = $clog2(FIFO_DEPTH);
  localparam int FCW = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } c2d_meta_t;

  logic [WW-1:0]         img_w;
  logic [HW-1:0]         img_h;
  logic [COEF_ROW_W-1:0] kernel [K];
  logic [WW-1:0]         w_clamped;
  logic [HW-1:0]         h_clamped;

  logic [CW-1:0]  in_col, in_col_next;
  logic [IRW-1:0] in_row, in_row_next;
  logic [FW-1:0]  fill, fill_next;
  logic [RW-1:0]  emit_row, emit_row_next;
  logic [CW-1:0]  emit_col, emit_col_next;

  logic cfg_wr, dim_wr, kern_wr;
  logic take, is_drain, in_frame, adv, emit, last;
  logic col_wrap, emit_col_wrap;
  logic [FW-1:0]  lag;
  logic [PIX_W-1:0] x_new;

  logic [LINE_W-1:0] ram_q, line, line_wr, byp_data;
  logic              byp;

  logic [K-1:0] row_ok_now, col_ok_now, row_ok1, col_ok1;
  logic [HCMP-1:0] rsum;
  logic [CMPW-1:0] csum;

  logic      v1, v2, v3;
  c2d_meta_t m1, m2, m3;

  c2d_cell_ctrl_t          cell_ctrl [K];
  logic [PIX_W-1:0]        cell_in   [K];
  logic signed [ROW_W-1:0] row_sums  [K];
  logic signed [SUM_W-1:0] total;

  c2d_out_t       fifo_mem [FIFO_DEPTH];
  logic [FPW-1:0] wr_ptr, rd_ptr;
  logic [FCW-1:0] fifo_cnt, occ;
  logic           push, pop;

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign dim_wr    = cfg_wr && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
  assign kern_wr   = cfg_wr && cfg_index >= REG_KERNEL_ROW_0 && cfg_index <= REG_KERNEL_ROW_4;

  always_comb begin
    if (cfg_data[DIM_W-1:0] == '0) begin
      w_clamped = WW'(1);
      h_clamped = HW'(1);
    end else begin
      if (int'(cfg_data[DIM_W-1:0]) > MAX_WIDTH) begin
        w_clamped = WW'(MAX_WIDTH);
      end else begin
        w_clamped = WW'(cfg_data[DIM_W-1:0]);
      end
      if (int'(cfg_data[DIM_W-1:0]) > MAX_HEIGHT) begin
        h_clamped = HW'(MAX_HEIGHT);
      end else begin
        h_clamped = HW'(cfg_data[DIM_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= WW'(W_RESET);
      img_h <= HW'(H_RESET);
      for (int a = 0; a < K; a++) begin
        kernel[a] <= KERNEL_ROW_RESET;
      end
    end else begin
      if (cfg_wr && cfg_index == REG_IMAGE_WIDTH) begin
        img_w <= w_clamped;
      end
      if (cfg_wr && cfg_index == REG_IMAGE_HEIGHT) begin
        img_h <= h_clamped;
      end
      if (kern_wr) begin
        kernel[KIW'(cfg_index - REG_KERNEL_ROW_0)] <= cfg_data;
      end
    end
  end

  // raster position of input and output
  assign take     = pix_valid && pix_ready;
  assign is_drain = (pix_data.action == ACT_DRAIN);
  assign in_frame = in_row < IRW'(img_h);
  assign adv      = take && (in_frame ? !is_drain : is_drain);
  assign lag      = FW'(PAD * int'(img_w) + PAD);
  assign emit     = adv && (fill == lag);
  assign col_wrap      = (CMPW'(in_col) + CMPW'(1)) >= CMPW'(img_w);
  assign emit_col_wrap = (CMPW'(emit_col) + CMPW'(1)) >= CMPW'(img_w);
  assign last     = emit_col_wrap && ((HCMP'(emit_row) + HCMP'(1)) == HCMP'(img_h));
  assign x_new    = is_drain ? '0 : pix_data.pixel;

  always_comb begin
    in_col_next   = in_col;
    in_row_next   = in_row;
    fill_next     = fill;
    emit_row_next = emit_row;
    emit_col_next = emit_col;
    if (dim_wr) begin
      in_col_next   = '0;
      in_row_next   = '0;
      fill_next     = '0;
      emit_row_next = '0;
      emit_col_next = '0;
    end else if (adv) begin
      if (col_wrap) begin
        in_col_next = '0;
        in_row_next = in_row + 1'b1;
      end else begin
        in_col_next = in_col + 1'b1;
      end
      if (emit) begin
        if (last) begin
          in_col_next   = '0;
          in_row_next   = '0;
          fill_next     = '0;
          emit_row_next = '0;
          emit_col_next = '0;
        end else if (emit_col_wrap) begin
          emit_col_next = '0;
          emit_row_next = emit_row + 1'b1;
        end else begin
          emit_col_next = emit_col + 1'b1;
        end
      end else begin
        fill_next = fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_row   <= '0;
      fill     <= '0;
      emit_row <= '0;
      emit_col <= '0;
    end else begin
      in_col   <= in_col_next;
      in_row   <= in_row_next;
      fill     <= fill_next;
      emit_row <= emit_row_next;
      emit_col <= emit_col_next;
    end
  end

  // line ram, one column per address, four rows per word, read one column ahead
  assign line    = byp ? byp_data : ram_q;
  assign line_wr = {line[LINE_W-PIX_W-1:0], x_new};

  c2d_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (adv),
    .wr_addr (in_col),
    .wr_data (line_wr),
    .rd_addr (in_col_next),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= adv && (in_col_next == in_col);
    end
    byp_data <= line_wr;
  end

  // padding masks of the window being emitted
  always_comb begin
    rsum = '0;
    csum = '0;
    for (int a = 0; a < K; a++) begin
      rsum = HCMP'(emit_row) + HCMP'(a);
      row_ok_now[a] = (rsum >= HCMP'(PAD)) && (rsum < HCMP'(img_h) + HCMP'(PAD));
      csum = CMPW'(emit_col) + CMPW'(a);
      col_ok_now[a] = (csum >= CMPW'(PAD)) && (csum < CMPW'(img_w) + CMPW'(PAD));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_ok1 <= row_ok_now;
      col_ok1 <= col_ok_now;
      m1.row  <= POS_W'(emit_row);
      m1.col  <= POS_W'(emit_col);
      m1.last <= last;
    end
    m2 <= m1;
    m3 <= m2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= emit;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // chain of row cells
  for (genvar a = 0; a < K; a++) begin : g_cell
    if (a == K - 1) begin : g_head
      assign cell_in[a] = x_new;
    end else begin : g_tail
      assign cell_in[a] = line[(K-2-a)*PIX_W +: PIX_W];
    end

    assign cell_ctrl[a].shift  = adv;
    assign cell_ctrl[a].row_ok = row_ok1[a];
    assign cell_ctrl[a].col_ok = col_ok1;

    c2d_row_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl[a]),
      .pix_in  (cell_in[a]),
      .coefs   (kernel[a]),
      .row_sum (row_sums[a])
    );
  end

  always_comb begin
    total = '0;
    for (int a = 0; a < K; a++) begin
      total = total + SUM_W'(row_sums[a]);
    end
  end

  // result buffer
  assign push      = v3;
  assign pop       = res_valid && res_ready;
  assign res_valid = (fifo_cnt != '0);
  assign res_data  = fifo_mem[rd_ptr];
  assign occ       = fifo_cnt + FCW'(v1) + FCW'(v2) + FCW'(v3);
  assign pix_ready = occ < FCW'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr].filtered_sum  <= total;
      fifo_mem[wr_ptr].out_row       <= m3.row;
      fifo_mem[wr_ptr].out_col       <= m3.col;
      fifo_mem[wr_ptr].last_in_frame <= m3.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fifo_cnt <= fifo_cnt + 1'b1;
        2'b01:   fifo_cnt <= fifo_cnt - 1'b1;
        default: fifo_cnt <= fifo_cnt;
      endcase
    end
  end

endmodule

FILE: design/c2d_ram.sv
// c2d_ram: generic single write port, single read port ram with registered read
// no dependencies

module c2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/c2d_row_cell.sv
// c2d_row_cell: one kernel row of the window, five pixel taps, products and row sum
// depends on c2d_pkg

module c2d_row_cell import c2d_pkg::*; (
  input  logic                    clk,
  input  c2d_cell_ctrl_t          ctrl,
  input  logic [PIX_W-1:0]        pix_in,
  input  logic [COEF_ROW_W-1:0]   coefs,
  output logic signed [ROW_W-1:0] row_sum
);

  logic [PIX_W-1:0]         taps      [K];
  logic signed [PROD_W-1:0] prods     [K];
  logic signed [PROD_W-1:0] prods_next[K];
  logic signed [ROW_W-1:0]  row_sum_next;

  // newest pixel enters at the right-hand tap
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      taps[K-1] <= pix_in;
      for (int b = 0; b < K - 1; b++) begin
        taps[b] <= taps[b+1];
      end
    end
  end

  always_comb begin
    for (int b = 0; b < K; b++) begin
      if (ctrl.row_ok && ctrl.col_ok[b]) begin
        prods_next[b] = $signed(coefs[b*COEF_W +: COEF_W]) * $signed({1'b0, taps[b]});
      end else begin
        prods_next[b] = '0;
      end
    end
  end

  always_comb begin
    row_sum_next = '0;
    for (int b = 0; b < K; b++) begin
      row_sum_next = row_sum_next + ROW_W'(prods[b]);
    end
  end

  always_ff @(posedge clk) begin
    prods   <= prods_next;
    row_sum <= row_sum_next;
  end

endmodule

FILE: design/c2d_checker.sv
// c2d_checker: port-level checks of the convolution top level, bound to it below
// depends on c2d_pkg and conv2d_zero_padded_window_top

module c2d_checker import c2d_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     pix_valid,
  input logic     pix_ready,
  input logic     res_valid,
  input logic     res_ready,
  input c2d_out_t res_data
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // an empty result buffer only fills from an earlier input transfer
  a_res_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pix_valid && pix_ready, 4))
    else $error("result without matching input transfer");

  // input closes only when a result is held back
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(pix_ready) |-> $past(res_valid && !res_ready))
    else $error("input ready dropped without output stall");

endmodule

bind conv2d_zero_padded_window_top c2d_checker u_c2d_checker (.*);

FILE: sim/conv2d_zero_padded_window_top_tb.sv
// conv2d_zero_padded_window_top_tb: self-checking bench for the zero-padded 5x5 convolution
// streams directed and random frames, predicts every window sum and compares each result
// depends on c2d_pkg and conv2d_zero_padded_window_top

module conv2d_zero_padded_window_top_tb;
  import c2d_pkg::*;

  localparam int MAX_DIM = 64;
  localparam int LINE_ROWS = K + PAD;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 550;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [COEF_W-1:0] COEF_MIN = 8'h80;
  localparam logic [COEF_W-1:0] COEF_MAX = 8'h7f;

  typedef enum int { PIX_RANDOM, PIX_EXTREME, PIX_FULL } pix_mode_e;

  logic clk = 1'b0;
  logic rst;
  logic pix_valid;
  logic pix_ready;
  c2d_in_t pix_data;
  logic res_valid;
  logic res_ready;
  c2d_out_t res_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_ROW_W-1:0] cfg_data;

  // predictor state
  logic [DIM_W-1:0] cfg_width;
  logic [DIM_W-1:0] cfg_height;
  logic [COEF_ROW_W-1:0] cfg_kernel [K];
  logic [PIX_W-1:0] line_mem [LINE_ROWS * MAX_DIM];
  int src_row, src_col, dst_row, dst_col;

  c2d_out_t expected_sums [$];
  int mismatch_count = 0;
  int items_taken = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  logic [31:0] ready_pattern = '0;
  int pattern_bits = 0;

  conv2d_zero_padded_window_top #(
    .MAX_WIDTH (MAX_DIM),
    .MAX_HEIGHT(MAX_DIM)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix_data (pix_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int eff_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [COEF_ROW_W-1:0] dim_word(input int d);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    return {noise[COEF_ROW_W-1:DIM_W], d[DIM_W-1:0]};
  endfunction

  function automatic logic [COEF_ROW_W-1:0] coef_row(input logic [COEF_W-1:0] c);
    return {K{c}};
  endfunction

  function automatic logic [COEF_ROW_W-1:0] random_kernel_row();
    logic [63:0] bits;
    logic [COEF_ROW_W-1:0] row;
    logic [COEF_W-1:0] picks [5];
    picks = '{COEF_MIN, COEF_MAX, 8'h00, 8'hff, 8'h01};
    bits = {$urandom, $urandom};
    row = bits[COEF_ROW_W-1:0];
    if ($urandom_range(3) == 0) begin
      for (int j = 0; j < K; j++) row[COEF_W*j +: COEF_W] = picks[$urandom_range(4)];
    end
    return row;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input pix_mode_e mode);
    case (mode)
      PIX_EXTREME: return $urandom_range(1) ? 8'hff : 8'h00;
      PIX_FULL: return 8'hff;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic void restart_counters();
    src_row = 0;
    src_col = 0;
    dst_row = 0;
    dst_col = 0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [COEF_ROW_W-1:0] value);
    case (idx)
      REG_IMAGE_WIDTH: begin
        cfg_width = value[DIM_W-1:0];
        restart_counters();
      end
      REG_IMAGE_HEIGHT: begin
        cfg_height = value[DIM_W-1:0];
        restart_counters();
      end
      default: begin
        if (idx >= REG_KERNEL_ROW_0 && idx <= REG_KERNEL_ROW_4)
          cfg_kernel[idx - REG_KERNEL_ROW_0] = value;
      end
    endcase
  endfunction

  // one accepted item; queues the window sum that it completes, if any
  function automatic bit convolve_step(input c2d_in_t item);
    int w, h, cnt, lin, lag, sum, rr, cc;
    logic [PIX_W-1:0] tap;
    logic signed [COEF_W-1:0] coef;
    c2d_out_t res;
    w = eff_dim(cfg_width);
    h = eff_dim(cfg_height);
    if (src_row >= h) begin
      if (item.action == ACT_PIXEL) return 1'b0;
    end else begin
      if (item.action == ACT_DRAIN) return 1'b0;
      line_mem[(src_row % LINE_ROWS) * MAX_DIM + src_col] = item.pixel;
    end
    src_col++;
    if (src_col >= w) begin
      src_col = 0;
      src_row++;
    end
    cnt = src_row * w + src_col;
    lin = dst_row * w + dst_col;
    lag = PAD * w + PAD;
    if (cnt < lin + lag + 1) return 1'b1;
    sum = 0;
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        rr = dst_row + i - PAD;
        cc = dst_col + j - PAD;
        tap = '0;
        if (rr >= 0 && rr < h && cc >= 0 && cc < w)
          tap = line_mem[(rr % LINE_ROWS) * MAX_DIM + cc];
        coef = cfg_kernel[i][COEF_W*j +: COEF_W];
        sum += int'(coef) * int'(tap);
      end
    end
    res.filtered_sum = sum[SUM_W-1:0];
    res.out_row = dst_row[POS_W-1:0];
    res.out_col = dst_col[POS_W-1:0];
    res.last_in_frame = (dst_row == h - 1) && (dst_col == w - 1);
    expected_sums.push_back(res);
    if (res.last_in_frame) begin
      restart_counters();
    end else begin
      dst_col++;
      if (dst_col >= w) begin
        dst_col = 0;
        dst_row++;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_item(input logic action, input logic [PIX_W-1:0] pixel);
    c2d_in_t item;
    int gap;
    item.action = action;
    item.pixel = pixel;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      repeat (gap) begin
        @(negedge clk);
        pix_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    pix_valid <= 1'b1;
    pix_data <= item;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    if (convolve_step(item)) items_taken++;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [COEF_ROW_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold the input until every queued result has been taken
  task automatic settle();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic stream_pixels(input int n, input pix_mode_e mode);
    repeat (n) begin
      if (src_row < eff_dim(cfg_height)) send_item(ACT_PIXEL, pick_pixel(mode));
    end
  endtask

  task automatic stream_frame(input pix_mode_e mode, input int noise_pct);
    while (src_row < eff_dim(cfg_height)) begin
      if ($urandom_range(99) < noise_pct) send_item(ACT_DRAIN, PIX_W'($urandom));
      send_item(ACT_PIXEL, pick_pixel(mode));
    end
    while (src_row >= eff_dim(cfg_height)) begin
      if ($urandom_range(99) < noise_pct) send_item(ACT_PIXEL, PIX_W'($urandom));
      send_item(ACT_DRAIN, PIX_W'($urandom));
    end
  endtask

  task automatic set_frame(input int w, input int h);
    write_register(REG_IMAGE_WIDTH, dim_word(w));
    write_register(REG_IMAGE_HEIGHT, dim_word(h));
  endtask

  task automatic set_kernel(input logic [COEF_W-1:0] c);
    for (int i = 0; i < K; i++) write_register(REG_KERNEL_ROW_0 + i, coef_row(c));
  endtask

  task automatic test_reset_defaults();
    send_item(ACT_DRAIN, 8'h00);
    stream_pixels(3 * MAX_DIM, PIX_RANDOM);
    settle();
  endtask

  task automatic test_sum_extremes();
    set_frame(5, 5);
    set_kernel(COEF_MIN);
    stream_frame(PIX_FULL, 0);
    settle();
    set_kernel(COEF_MAX);
    stream_frame(PIX_FULL, 0);
    settle();
    for (int i = 0; i < K; i++) write_register(REG_KERNEL_ROW_0 + i, random_kernel_row());
    stream_frame(PIX_EXTREME, 0);
    settle();
  endtask

  task automatic test_ignored_items();
    set_frame(3, 2);
    send_item(ACT_DRAIN, 8'hff);
    stream_pixels(4, PIX_RANDOM);
    send_item(ACT_DRAIN, 8'h5a);
    stream_pixels(2, PIX_RANDOM);
    send_item(ACT_PIXEL, 8'ha5);
    stream_frame(PIX_RANDOM, 0);
    settle();
  endtask

  task automatic test_dimension_clamp();
    set_frame(0, 127);
    stream_frame(PIX_RANDOM, 0);
    settle();
    set_frame(100, 0);
    stream_frame(PIX_RANDOM, 0);
    settle();
    set_frame(1, 1);
    stream_frame(PIX_EXTREME, 0);
    settle();
  endtask

  task automatic test_mid_frame_writes();
    set_frame(6, 5);
    stream_pixels(20, PIX_RANDOM);
    settle();
    write_register(REG_KERNEL_ROW_0 + 2, random_kernel_row());
    write_register(REG_UNUSED, random_kernel_row());
    stream_frame(PIX_RANDOM, 0);
    settle();
    stream_pixels(10, PIX_RANDOM);
    settle();
    write_register(REG_IMAGE_HEIGHT, dim_word(4));
    stream_frame(PIX_RANDOM, 0);
    settle();
    stream_pixels(17, PIX_RANDOM);
    settle();
    write_register(REG_IMAGE_WIDTH, dim_word(7));
    stream_frame(PIX_RANDOM, 0);
    settle();
  endtask

  task automatic test_random_frames();
    int start_count;
    int w, h;
    pix_mode_e mode;
    start_count = items_taken;
    while (items_taken - start_count < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(3) == 0) begin
        w = ($urandom_range(7) == 0) ? 0 : $urandom_range(8, 1);
        h = ($urandom_range(7) == 0) ? 0 : $urandom_range(8, 1);
        set_frame(w, h);
      end
      for (int i = 0; i < K; i++) begin
        if ($urandom_range(1) == 0) write_register(REG_KERNEL_ROW_0 + i, random_kernel_row());
      end
      if ($urandom_range(9) == 0) write_register(REG_UNUSED, random_kernel_row());
      mode = ($urandom_range(4) == 0) ? PIX_EXTREME : PIX_RANDOM;
      if ($urandom_range(5) == 0) begin
        stream_pixels($urandom_range(30, 1), mode);
        settle();
        case ($urandom_range(2))
          0: write_register(REG_KERNEL_ROW_0 + $urandom_range(K - 1), random_kernel_row());
          1: write_register(REG_IMAGE_WIDTH, dim_word($urandom_range(8, 1)));
          default: write_register(REG_IMAGE_HEIGHT, dim_word($urandom_range(8, 1)));
        endcase
      end
      stream_frame(mode, ($urandom_range(2) == 0) ? 8 : 0);
    end
  endtask

  // receiver stalls follow a rolling 32-bit pattern
  always @(negedge clk) begin
    if (pattern_bits == 0) begin
      case ($urandom_range(3))
        0: ready_pattern = '1;
        1: ready_pattern = $urandom;
        2: ready_pattern = $urandom | $urandom;
        default: ready_pattern = {16'hffff, 16'h0000};
      endcase
      pattern_bits = 32;
    end
    res_ready <= ready_pattern[0];
    ready_pattern = ready_pattern >> 1;
    pattern_bits--;
  end

  always @(posedge clk) begin
    c2d_out_t exp_res;
    if (!rst && res_valid && res_ready) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result row %0d col %0d", res_data.out_row, res_data.out_col);
        mismatch_count++;
      end else begin
        exp_res = expected_sums.pop_front();
        if (res_data.filtered_sum !== exp_res.filtered_sum) begin
          $error("filtered_sum: expected %0d, actual %0d",
                 exp_res.filtered_sum, res_data.filtered_sum);
          mismatch_count++;
        end
        if (res_data.out_row !== exp_res.out_row) begin
          $error("out_row: expected %0d, actual %0d", exp_res.out_row, res_data.out_row);
          mismatch_count++;
        end
        if (res_data.out_col !== exp_res.out_col) begin
          $error("out_col: expected %0d, actual %0d", exp_res.out_col, res_data.out_col);
          mismatch_count++;
        end
        if (res_data.last_in_frame !== exp_res.last_in_frame) begin
          $error("last_in_frame: expected %0d, actual %0d",
                 exp_res.last_in_frame, res_data.last_in_frame);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    pix_valid = 1'b0;
    pix_data = '0;
    res_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_width = DIM_W'(DIM_RESET);
    cfg_height = DIM_W'(DIM_RESET);
    for (int i = 0; i < K; i++) cfg_kernel[i] = KERNEL_ROW_RESET;
    for (int i = 0; i < LINE_ROWS * MAX_DIM; i++) line_mem[i] = '0;
    restart_counters();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_sum_extremes();
    test_ignored_items();
    test_dimension_clamp();
    test_mid_frame_writes();
    test_random_frames();
    settle();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && expected_sums.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
